>>> hdl/tig_pkg.sv
// ----------------------------------------------------------------------------
// tig_pkg
// shared constants and types for the triangle index generator
// ----------------------------------------------------------------------------
package tig_pkg;

   localparam int unsigned MAX_POINTS_DEFAULT = 66;

   localparam int unsigned IDX_W  = 16;
   localparam int unsigned PTS_W  = 7;
   localparam int unsigned NEED_W = 8;
   localparam int unsigned STAT_W = 3;
   localparam int unsigned CSR_IDX_W = 8;

   // primitive kinds
   localparam logic [1:0] MODE_TRIANGLE = 2'd0;
   localparam logic [1:0] MODE_QUAD     = 2'd1;
   localparam logic [1:0] MODE_STRIP    = 2'd2;
   localparam logic [1:0] MODE_FAN      = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_TOO_FEW   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_IDX_OVF   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_VTX_OVF   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_TOO_MANY  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_CAP = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_CAP  = 8'd1;

   typedef struct packed {
      logic [IDX_W-1:0]  count;
      logic [NEED_W-1:0] need;
      logic [IDX_W-1:0]  cap;
   } alu_req_type;

   typedef struct packed {
      logic [IDX_W:0] sum;
      logic           over;
   } alu_rsp_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  base_vertex;
      logic [IDX_W-1:0]  index_c;
      logic [IDX_W-1:0]  index_b;
      logic [IDX_W-1:0]  index_a;
   } rsp_item_type;

endpackage

>>> hdl/tig_alu.sv
// ----------------------------------------------------------------------------
// tig_alu
// shared add and capacity compare unit
// ----------------------------------------------------------------------------
module tig_alu (
   input  tig_pkg::alu_req_type alu_req,
   output tig_pkg::alu_rsp_type alu_rsp
);

   logic [tig_pkg::IDX_W:0] sum;

   // full-width sum so a wrap never hides an overflow
   assign sum = {1'b0, alu_req.count}
              + {{(tig_pkg::IDX_W + 1 - tig_pkg::NEED_W){1'b0}}, alu_req.need};

   assign alu_rsp.sum  = sum;
   assign alu_rsp.over = sum > {1'b0, alu_req.cap};

endmodule

>>> hdl/tig_seq.sv
// ----------------------------------------------------------------------------
// tig_seq
// request sequencer: point checks, capacity checks, triangle emission
// ----------------------------------------------------------------------------
module tig_seq #(
   parameter int unsigned MaxPoints = tig_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [tig_pkg::PTS_W-1:0]     req_points,
   input  logic [tig_pkg::IDX_W-1:0]     vertex_cap,
   input  logic [tig_pkg::IDX_W-1:0]     index_cap,
   output tig_pkg::alu_req_type          alu_req,
   input  tig_pkg::alu_rsp_type          alu_rsp,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tig_pkg::rsp_item_type         rsp_item,
   output logic                          rsp_last
);

   localparam logic [tig_pkg::PTS_W-1:0] MaxPts = tig_pkg::PTS_W'(MaxPoints);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHKI,
      S_CHKV,
      S_EMIT,
      S_ERR
   } state_type;

   state_type                      state_ff, state_in;
   logic [1:0]                     mode_ff, mode_in;
   logic [tig_pkg::PTS_W-1:0]      pts_ff, pts_in;
   logic [tig_pkg::PTS_W-1:0]      left_ff, left_in;
   logic [tig_pkg::STAT_W-1:0]     err_ff, err_in;
   logic [tig_pkg::IDX_W-1:0]      vcount_ff, vcount_in;
   logic [tig_pkg::IDX_W-1:0]      icount_ff, icount_in;
   logic [tig_pkg::IDX_W-1:0]      isum_ff, isum_in;
   logic [tig_pkg::IDX_W-1:0]      a_ff, a_in;
   logic [tig_pkg::IDX_W-1:0]      b_ff, b_in;
   logic [tig_pkg::IDX_W-1:0]      c_ff, c_in;
   logic [tig_pkg::IDX_W-1:0]      base_ff, base_in;
   logic                           rvalid_ff, rvalid_in;
   tig_pkg::rsp_item_type          ritem_ff, ritem_in;
   logic                           rlast_ff, rlast_in;

   logic                           accept;
   logic                           out_free;
   logic                           is_list;
   logic [tig_pkg::NEED_W-1:0]     ineed;
   logic [tig_pkg::PTS_W-1:0]      tris_new;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rvalid_ff | rsp_ready;
   assign is_list   = (req_mode == tig_pkg::MODE_STRIP) | (req_mode == tig_pkg::MODE_FAN);
   assign tris_new  = (req_mode == tig_pkg::MODE_QUAD) ? tig_pkg::PTS_W'(2) :
                      (req_mode == tig_pkg::MODE_TRIANGLE) ? tig_pkg::PTS_W'(1) :
                      req_points - tig_pkg::PTS_W'(2);

   // three indices per triangle
   assign ineed = {1'b0, left_ff} + {left_ff, 1'b0};

   always_comb begin
      alu_req.count = vcount_ff;
      alu_req.need  = {1'b0, pts_ff};
      alu_req.cap   = vertex_cap;
      if (state_ff == S_CHKI) begin
         alu_req.count = icount_ff;
         alu_req.need  = ineed;
         alu_req.cap   = index_cap;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      pts_in    = pts_ff;
      left_in   = left_ff;
      err_in    = err_ff;
      vcount_in = vcount_ff;
      icount_in = icount_ff;
      isum_in   = isum_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      base_in   = base_ff;
      rvalid_in = rvalid_ff & ~rsp_ready;
      ritem_in  = ritem_ff;
      rlast_in  = rlast_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               left_in = tris_new;
               pts_in  = is_list ? req_points :
                         (req_mode == tig_pkg::MODE_QUAD) ? tig_pkg::PTS_W'(4) :
                         tig_pkg::PTS_W'(3);
               if (is_list && req_points < tig_pkg::PTS_W'(3)) begin
                  err_in   = tig_pkg::STAT_TOO_FEW;
                  state_in = S_ERR;
               end else if (is_list && req_points > MaxPts) begin
                  err_in   = tig_pkg::STAT_TOO_MANY;
                  state_in = S_ERR;
               end else begin
                  state_in = S_CHKI;
               end
            end
         end
         S_CHKI: begin
            if (alu_rsp.over) begin
               err_in   = tig_pkg::STAT_IDX_OVF;
               state_in = S_ERR;
            end else begin
               isum_in  = alu_rsp.sum[tig_pkg::IDX_W-1:0];
               state_in = S_CHKV;
            end
         end
         S_CHKV: begin
            if (alu_rsp.over) begin
               err_in   = tig_pkg::STAT_VTX_OVF;
               state_in = S_ERR;
            end else begin
               icount_in = isum_ff;
               vcount_in = alu_rsp.sum[tig_pkg::IDX_W-1:0];
               base_in   = vcount_ff;
               a_in      = vcount_ff;
               b_in      = vcount_ff + tig_pkg::IDX_W'(1);
               c_in      = vcount_ff + tig_pkg::IDX_W'(2);
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rvalid_in            = 1'b1;
               ritem_in.index_a     = a_ff;
               ritem_in.index_b     = b_ff;
               ritem_in.index_c     = c_ff;
               ritem_in.base_vertex = base_ff;
               ritem_in.status      = tig_pkg::STAT_OK;
               rlast_in             = (left_ff == tig_pkg::PTS_W'(1));
               // strip slides all three; fan and quad keep the hub vertex
               if (mode_ff == tig_pkg::MODE_STRIP) begin
                  a_in = a_ff + tig_pkg::IDX_W'(1);
               end
               b_in    = b_ff + tig_pkg::IDX_W'(1);
               c_in    = c_ff + tig_pkg::IDX_W'(1);
               left_in = left_ff - tig_pkg::PTS_W'(1);
               if (left_ff == tig_pkg::PTS_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rvalid_in            = 1'b1;
               ritem_in.index_a     = '0;
               ritem_in.index_b     = '0;
               ritem_in.index_c     = '0;
               ritem_in.base_vertex = '0;
               ritem_in.status      = err_ff;
               rlast_in             = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vcount_ff <= '0;
         icount_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         icount_ff <= icount_in;
         rvalid_ff <= rvalid_in;
      end
      mode_ff  <= mode_in;
      pts_ff   <= pts_in;
      left_ff  <= left_in;
      err_ff   <= err_in;
      isum_ff  <= isum_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      base_ff  <= base_in;
      ritem_ff <= ritem_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_item  = ritem_ff;
   assign rsp_last  = rlast_ff;

   // error results always close the request
   a_err_last : assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && ritem_ff.status != tig_pkg::STAT_OK) |-> rlast_ff)
      else $error("error result without last");

   // counters only move on a passed vertex check
   a_cnt_commit : assert property (@(posedge clock) disable iff (reset)
      (vcount_ff != $past(vcount_ff) || icount_ff != $past(icount_ff))
         |-> ($past(state_ff) == S_CHKV))
      else $error("counter update outside commit");

   // every good triangle has consecutive second and third indices
   a_tri_shape : assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && ritem_ff.status == tig_pkg::STAT_OK)
         |-> (ritem_ff.index_c == ritem_ff.index_b + tig_pkg::IDX_W'(1)))
      else $error("malformed triangle");

   // emission never runs out of triangles
   a_left_nz : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (left_ff != '0))
      else $error("emit with no triangles left");

endmodule

>>> hdl/triangle_index_generator.sv
// ----------------------------------------------------------------------------
// triangle_index_generator
// turns triangle, quad, strip and fan requests into triangle index triples
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     mode, point_count
//  rsp      out        rsp_tvalid/tready     indices, base vertex, status, last
//  csr      in         csr_valid/ready       register index, write data
//
//  after the accepting cycle, two capacity checks on the shared add/compare unit
//  (index buffer, then vertex buffer), then one triangle per cycle into the output
//  register whenever that register is free; a failed point or capacity check
//  instead puts a single error result into the output register
//  synchronous active-high reset clears both counters and sets both capacities
//  to 65535; a stalled result register stalls emission, and a new request is
//  taken once the last result of the previous one is in the output register
//
module triangle_index_generator #(
   parameter int unsigned MaxPoints = tig_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: [1:0] mode, [8:2] point_count, rest zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,
   // result: [15:0] index_a, [31:16] index_b, [47:32] index_c, [63:48] base_vertex
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,
   // result kind: [2:0] status
   output logic [tig_pkg::STAT_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tig_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                       csr_data
);

   logic [tig_pkg::IDX_W-1:0] vertex_cap_ff;
   logic [tig_pkg::IDX_W-1:0] index_cap_ff;
   logic                      csr_write;

   tig_pkg::alu_req_type      alu_req;
   tig_pkg::alu_rsp_type      alu_rsp;
   tig_pkg::rsp_item_type     rsp_item;

   // writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_cap_ff <= '1;
         index_cap_ff  <= '1;
      end else if (csr_write) begin
         if (csr_index == tig_pkg::CSR_VERTEX_CAP) begin
            vertex_cap_ff <= csr_data;
         end
         if (csr_index == tig_pkg::CSR_INDEX_CAP) begin
            index_cap_ff <= csr_data;
         end
      end
   end

   // single adder and comparator shared by both capacity checks
   tig_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   tig_seq #(
      .MaxPoints (MaxPoints)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tdata[1:0]),
      .req_points (req_tdata[8:2]),
      .vertex_cap (vertex_cap_ff),
      .index_cap  (index_cap_ff),
      .alu_req    (alu_req),
      .alu_rsp    (alu_rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item),
      .rsp_last   (rsp_tlast)
   );

   // pack the result register onto the stream
   assign rsp_tdata = {rsp_item.base_vertex, rsp_item.index_c,
                       rsp_item.index_b, rsp_item.index_a};
   assign rsp_tuser = rsp_item.status;

endmodule
